@@ rtl/code_symbol_pair_bit_packer_unit_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the code/symbol pair bit packer
// Shared property wrappers, clocked on clk and disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef CODE_SYMBOL_PAIR_BIT_PACKER_UNIT_MACROS_SVH
`define CODE_SYMBOL_PAIR_BIT_PACKER_UNIT_MACROS_SVH

// same-cycle implication
`define CSP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CSP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/csp_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csp_pkg
// Widths, action codes and the merge result type of the bit packer.
// ---------------------------------------------------------------------------
package csp_pkg;

    localparam int CODE_WIDTH  = 16;
    localparam int CODE_IN_W   = 16;
    localparam int SYM_W       = 8;
    localparam int LEN_IN_W    = 5;
    localparam int BYTE_W      = 8;
    localparam int PEND_W      = 7;
    localparam int PCNT_W      = 3;
    localparam int CLEN_W      = $clog2(CODE_WIDTH + 1);
    localparam int ACC_W       = PEND_W + CODE_WIDTH + SYM_W;
    localparam int NBITS_W     = $clog2(ACC_W + 1);
    localparam int MAX_BYTES   = ACC_W / BYTE_W;
    localparam int BCNT_W      = $clog2(MAX_BYTES + 1);
    localparam int BUF_W       = MAX_BYTES * BYTE_W;

    localparam logic ACT_PAIR  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef struct packed {
        logic [BUF_W-1:0]  bytes;
        logic [BCNT_W-1:0] nbytes;
        logic [PEND_W-1:0] pend_bits;
        logic [PCNT_W-1:0] pend_cnt;
    } csp_merge_t;

endpackage

@@ rtl/csp_merge.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// csp_merge
// Appends a pair to held bits and splits off whole bytes; a flush pads them out.
// ---------------------------------------------------------------------------
module csp_merge
    import csp_pkg::*;
(
    input  logic                 action,
    input  logic [CODE_IN_W-1:0] code_value,
    input  logic [SYM_W-1:0]     symbol_byte,
    input  logic [LEN_IN_W-1:0]  bit_length,
    input  logic [PEND_W-1:0]    pend_bits,
    input  logic [PCNT_W-1:0]    pend_cnt,
    output csp_merge_t           merge
);

    logic [CLEN_W-1:0]     len_sat;
    logic [CODE_WIDTH-1:0] code_ext;
    logic [CODE_WIDTH-1:0] code_mask;
    logic [ACC_W-1:0]      acc;
    logic [NBITS_W-1:0]    sym_pos;
    logic [NBITS_W-1:0]    nbits;
    logic [BCNT_W-1:0]     nbytes;
    logic [ACC_W-1:0]      rest;

    always_comb
    begin
        if (32'(bit_length) > CODE_WIDTH)
        begin
            len_sat = CLEN_W'(CODE_WIDTH);
        end
        else
        begin
            len_sat = CLEN_W'(bit_length);
        end
        for (int i = 0; i < CODE_WIDTH; i++)
        begin
            code_mask[i] = (i < int'(len_sat));
        end
    end

    assign code_ext = CODE_WIDTH'(code_value) & code_mask;
    assign sym_pos  = NBITS_W'(pend_cnt) + NBITS_W'(len_sat);
    assign nbits    = sym_pos + NBITS_W'(SYM_W);
    assign acc      = ACC_W'(pend_bits)
                    | (ACC_W'(code_ext) << pend_cnt)
                    | (ACC_W'(symbol_byte) << sym_pos);
    assign nbytes   = BCNT_W'(nbits >> 3);
    assign rest     = acc >> (NBITS_W'(nbytes) << 3);

    always_comb
    begin
        if (action == ACT_FLUSH)
        begin
            merge.bytes     = BUF_W'(pend_bits);
            merge.nbytes    = BCNT_W'(pend_cnt != '0);
            merge.pend_bits = '0;
            merge.pend_cnt  = '0;
        end
        else
        begin
            merge.bytes     = acc[BUF_W-1:0];
            merge.nbytes    = nbytes;
            merge.pend_bits = rest[PEND_W-1:0];
            merge.pend_cnt  = nbits[PCNT_W-1:0];
        end
    end

endmodule

@@ rtl/code_symbol_pair_bit_packer_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// code_symbol_pair_bit_packer_unit
// LSB-first packer of code/symbol pairs into a byte stream, with flush.
// ---------------------------------------------------------------------------
// The first byte of a request is offered in the cycle after it is accepted.
// One byte per cycle on the single-byte output channel while out_ready is
// high; a pair yields 1 to 3 bytes from the byte buffer, and the next request
// can be accepted as the last byte is taken. A flush with nothing held gives no byte.
// Reset (rst_n, async, low) empties the byte buffer by zeroing its count, and clears the held bits.
module code_symbol_pair_bit_packer_unit
    import csp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 action,
    input  logic [CODE_IN_W-1:0] code_value,
    input  logic [SYM_W-1:0]     symbol_byte,
    input  logic [LEN_IN_W-1:0]  bit_length,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BYTE_W-1:0]    out_byte,
    output logic                 last_of_run
);

`include "code_symbol_pair_bit_packer_unit_macros.svh"

    csp_merge_t         merge;
    logic [BUF_W-1:0]   buf_reg;
    logic [BUF_W-1:0]   buf_next;
    logic [BCNT_W-1:0]  cnt_reg;
    logic [BCNT_W-1:0]  cnt_next;
    logic [PEND_W-1:0]  pend_bits_reg;
    logic [PEND_W-1:0]  pend_bits_next;
    logic [PCNT_W-1:0]  pend_cnt_reg;
    logic [PCNT_W-1:0]  pend_cnt_next;
    logic               in_acc;
    logic               pop;

    csp_merge u_merge
    (
        .action      (action),
        .code_value  (code_value),
        .symbol_byte (symbol_byte),
        .bit_length  (bit_length),
        .pend_bits   (pend_bits_reg),
        .pend_cnt    (pend_cnt_reg),
        .merge       (merge)
    );

    assign out_valid   = (cnt_reg != '0);
    assign out_byte    = buf_reg[BYTE_W-1:0];
    assign last_of_run = (cnt_reg == BCNT_W'(1));
    assign pop         = out_valid && out_ready;
    assign in_ready    = (cnt_reg == '0) || (last_of_run && out_ready);
    assign in_acc      = in_valid && in_ready;

    always_comb
    begin
        buf_next       = buf_reg;
        cnt_next       = cnt_reg;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        if (in_acc)
        begin
            buf_next       = merge.bytes;
            cnt_next       = merge.nbytes;
            pend_bits_next = merge.pend_bits;
            pend_cnt_next  = merge.pend_cnt;
        end
        else if (pop)
        begin
            buf_next = buf_reg >> BYTE_W;
            cnt_next = cnt_reg - BCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    `CSP_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= BCNT_W'(MAX_BYTES), "byte count overflow")
    `CSP_ASSERT_IMP(a_pend_clean, 1'b1, (pend_bits_reg >> pend_cnt_reg) == '0, "dirty held bits")
    `CSP_ASSERT_NXT(a_pair_out, in_acc && (action == ACT_PAIR), out_valid, "pair gave no byte")
    `CSP_ASSERT_NXT(a_flush_empty, in_acc && (action == ACT_FLUSH), pend_cnt_reg == '0, "flush left bits")

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the code/symbol pair bit packer. A short table of
// requests (extremes, saturated lengths, flushes with and without held bits)
// is followed by ~400 random requests. Every request is run through a local
// bit-stream model; its bytes, or a typed row's table bytes, are queued and
// compared against the output channel. Both channels idle in random bursts;
// one long output hold-off forces the unit to back up and stall its input.
// ---------------------------------------------------------------------------
module tb_top;
    import csp_pkg::*;

    localparam int N_DIRECTED = 23;
    localparam int N_RANDOM   = 400;
    localparam int LONG_HOLD  = 150;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } out_beat_t;

    typedef struct {
        logic                 act;
        logic [CODE_IN_W-1:0] code;
        logic [SYM_W-1:0]     sym;
        logic [LEN_IN_W-1:0]  len;
        bit                   typed;
        int                   n;
        logic [23:0]          bytes;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 action;
    logic [CODE_IN_W-1:0] code_value;
    logic [SYM_W-1:0]     symbol_byte;
    logic [LEN_IN_W-1:0]  bit_length;
    logic                 out_valid;
    logic                 out_ready;
    logic [BYTE_W-1:0]    out_byte;
    logic                 last_of_run;

    out_beat_t         expected_bytes [$];
    out_beat_t         packed_beats [3];
    int                packed_n;
    logic [PEND_W-1:0] held_bits;
    logic [PCNT_W-1:0] held_cnt;

    stim_row_t directed_rows [N_DIRECTED];

    bit idle_on;
    bit hold_req;
    int mismatch_count;
    int request_count;
    int flush_count;
    int bytes_checked;

    code_symbol_pair_bit_packer_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .code_value  (code_value),
        .symbol_byte (symbol_byte),
        .bit_length  (bit_length),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic report(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // bit-stream model: appends code then symbol LSB first, emits whole bytes
    function automatic void pack_request(input logic act, input logic [CODE_IN_W-1:0] code,
                                         input logic [SYM_W-1:0] sym,
                                         input logic [LEN_IN_W-1:0] len);
        logic [31:0] acc;
        logic [31:0] code_bits;
        int          eff_len;
        int          nbits;
        packed_n = 0;
        if (act == ACT_FLUSH)
        begin
            if (held_cnt != '0)
            begin
                packed_beats[0] = '{data: {1'b0, held_bits}, last: 1'b1};
                packed_n  = 1;
                held_bits = '0;
                held_cnt  = '0;
            end
            return;
        end
        eff_len   = (int'(len) > CODE_WIDTH) ? CODE_WIDTH : int'(len);
        code_bits = (eff_len == 0) ? 32'h0 : ({16'h0, code} & ((32'h1 << eff_len) - 32'h1));
        acc   = {25'h0, held_bits};
        acc   = acc | (code_bits << held_cnt);
        acc   = acc | ({24'h0, sym} << (int'(held_cnt) + eff_len));
        nbits = int'(held_cnt) + eff_len + 8;
        while (nbits >= 8)
        begin
            packed_beats[packed_n] = '{data: acc[7:0], last: 1'b0};
            acc   = acc >> 8;
            nbits = nbits - 8;
            packed_n++;
        end
        packed_beats[packed_n-1].last = 1'b1;
        held_bits = acc[PEND_W-1:0];
        held_cnt  = nbits[PCNT_W-1:0];
    endfunction

    // call at a rising edge; returns at the edge where the request is taken
    task automatic send_request(input logic act, input logic [CODE_IN_W-1:0] code,
                                input logic [SYM_W-1:0] sym, input logic [LEN_IN_W-1:0] len,
                                input bit typed, input int n, input logic [23:0] bytes);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        code_value  <= code;
        symbol_byte <= sym;
        bit_length  <= len;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        request_count++;
        if (act == ACT_FLUSH)
        begin
            flush_count++;
        end
        pack_request(act, code, sym, len);
        if (typed)
        begin
            for (int k = 0; k < n; k++)
            begin
                expected_bytes.push_back('{data: bytes[8*k +: 8], last: (k == n - 1)});
            end
        end
        else
        begin
            for (int k = 0; k < packed_n; k++)
            begin
                expected_bytes.push_back(packed_beats[k]);
            end
        end
    endtask

    // output side: random stalls, plus one long hold-off on request
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        out_beat_t exp_beat;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                report($sformatf("unexpected byte %02h last=%0b", out_byte, last_of_run));
            end
            else
            begin
                exp_beat = expected_bytes.pop_front();
                bytes_checked++;
                if (out_byte !== exp_beat.data)
                begin
                    report($sformatf("out_byte %02h, expected %02h", out_byte, exp_beat.data));
                end
                if (last_of_run !== exp_beat.last)
                begin
                    report($sformatf("last_of_run %0b, expected %0b (byte %02h)",
                                     last_of_run, exp_beat.last, exp_beat.data));
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d bytes outstanding", expected_bytes.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        logic                 r_act;
        logic [CODE_IN_W-1:0] r_code;
        logic [SYM_W-1:0]     r_sym;
        logic [LEN_IN_W-1:0]  r_len;

        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        action         <= ACT_PAIR;
        code_value     <= '0;
        symbol_byte    <= '0;
        bit_length     <= '0;
        held_bits      = '0;
        held_cnt       = '0;
        idle_on        = 1'b1;
        hold_req       = 1'b0;
        mismatch_count = 0;
        request_count  = 0;
        flush_count    = 0;
        bytes_checked  = 0;

        directed_rows = '{
            '{ACT_FLUSH, 16'h0000, 8'h00, 5'd0,  1'b1, 0, 24'h000000},
            '{ACT_PAIR,  16'h0000, 8'hA5, 5'd0,  1'b1, 1, 24'h0000A5},
            '{ACT_PAIR,  16'hFFFF, 8'hFF, 5'd16, 1'b1, 3, 24'hFFFFFF},
            '{ACT_PAIR,  16'h1234, 8'h00, 5'd31, 1'b1, 3, 24'h001234},
            '{ACT_PAIR,  16'hFFFF, 8'h00, 5'd3,  1'b1, 1, 24'h000007},
            '{ACT_FLUSH, 16'hFFFF, 8'hFF, 5'd31, 1'b1, 1, 24'h000000},
            '{ACT_FLUSH, 16'h0000, 8'h00, 5'd0,  1'b1, 0, 24'h000000},
            '{ACT_PAIR,  16'h0001, 8'hFF, 5'd1,  1'b1, 1, 24'h0000FF},
            '{ACT_FLUSH, 16'h0000, 8'h00, 5'd0,  1'b1, 1, 24'h000001},
            '{ACT_PAIR,  16'h007F, 8'h00, 5'd7,  1'b1, 1, 24'h00007F},
            '{ACT_PAIR,  16'hFFFF, 8'hFF, 5'd16, 1'b0, 0, 24'h000000},
            '{ACT_PAIR,  16'hFFFF, 8'hFF, 5'd17, 1'b0, 0, 24'h000000},
            '{ACT_PAIR,  16'h8000, 8'h80, 5'd16, 1'b0, 0, 24'h000000},
            '{ACT_PAIR,  16'hAAAA, 8'h55, 5'd8,  1'b0, 0, 24'h000000},
            '{ACT_PAIR,  16'h5555, 8'hAA, 5'd15, 1'b0, 0, 24'h000000},
            '{ACT_FLUSH, 16'h0000, 8'h00, 5'd0,  1'b0, 0, 24'h000000},
            '{ACT_PAIR,  16'h0000, 8'h00, 5'd0,  1'b0, 0, 24'h000000},
            '{ACT_PAIR,  16'hFFFF, 8'h00, 5'd16, 1'b0, 0, 24'h000000},
            '{ACT_PAIR,  16'h0F0F, 8'hF0, 5'd4,  1'b0, 0, 24'h000000},
            '{ACT_PAIR,  16'hFFFF, 8'hFF, 5'd0,  1'b0, 0, 24'h000000},
            '{ACT_FLUSH, 16'h0000, 8'h00, 5'd0,  1'b0, 0, 24'h000000},
            '{ACT_PAIR,  16'hFFFF, 8'h7F, 5'd10, 1'b0, 0, 24'h000000},
            '{ACT_FLUSH, 16'h0000, 8'h00, 5'd0,  1'b0, 0, 24'h000000}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].act, directed_rows[i].code, directed_rows[i].sym,
                         directed_rows[i].len, directed_rows[i].typed, directed_rows[i].n,
                         directed_rows[i].bytes);
        end

        for (int j = 0; j < N_RANDOM; j++)
        begin
            idle_on = (j < 330) && ((j / 60) % 3 != 2);
            if (j == 150)
            begin
                hold_req = 1'b1;
            end
            r_act  = ($urandom_range(0, 99) < 12) ? ACT_FLUSH : ACT_PAIR;
            r_code = CODE_IN_W'($urandom_range(0, 65535));
            r_sym  = SYM_W'($urandom_range(0, 255));
            r_len  = ($urandom_range(0, 9) < 8) ? LEN_IN_W'($urandom_range(0, 16))
                                                : LEN_IN_W'($urandom_range(17, 31));
            send_request(r_act, r_code, r_sym, r_len, 1'b0, 0, 24'h0);
        end
        in_valid <= 1'b0;

        while (expected_bytes.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d requests (%0d flushes) sent, %0d output bytes checked",
                 request_count, flush_count, bytes_checked);
        $display("lengths 0..31, flushes with and without held bits, long output stall");
        if (mismatch_count == 0 && expected_bytes.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/csp_pkg.sv
rtl/csp_merge.sv
rtl/code_symbol_pair_bit_packer_unit.sv
tb/tb_top.sv
